// ===== hdl/son_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// son_pkg
// Types and constants shared by the outlier-slack normalizer.
// ----------------------------------------------------------------------------
package son_pkg;

  localparam int unsigned EntryW  = 16;
  localparam int unsigned SumW    = 24;
  localparam int unsigned RoundW  = 5;
  localparam int unsigned DimW    = 8;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [EntryW-1:0] OneQ15    = 16'd32768;
  localparam logic [EntryW-1:0] SlackInit = 16'd328;
  localparam logic [SumW-1:0]   SumMax    = 24'hFFFFFF;
  localparam logic [RoundW-1:0] RoundMax  = 5'd16;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_NORM  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROWS   = 2'd0,
    CFG_COLS   = 2'd1,
    CFG_ROUNDS = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_DONE = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  // divider request and reply
  typedef struct packed {
    logic            start;
    logic [EntryW-1:0] num;
    logic [SumW-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [EntryW-1:0] quo;
  } div_rsp_t;

  function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] a, logic [EntryW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {{(SumW-EntryW+1){1'b0}}, b};
    return s[SumW] ? SumMax : s[SumW-1:0];
  endfunction

endpackage

// ===== hdl/son_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// son_in_if / son_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface son_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [6:0]  row_index;
  logic [6:0]  col_index;
  logic [15:0] entry_value;
  modport source (output valid, action, row_index, col_index, entry_value, input ready);
  modport sink   (input valid, action, row_index, col_index, entry_value, output ready);
endinterface

interface son_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] read_value;
  modport source (output valid, result_kind, read_value, input ready);
  modport sink   (input valid, result_kind, read_value, output ready);
endinterface

// ===== hdl/son_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// son_div
// Restoring divider, one quotient bit per cycle:
// q = min(0xFFFF, floor((x*32768 + s/2) / s)).
// ----------------------------------------------------------------------------
module son_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  son_pkg::div_req_t req_i,
  output son_pkg::div_rsp_t rsp_o
);
  import son_pkg::*;

  localparam int unsigned NumW = EntryW + 15 + 1;  // x*32768 + s/2 fits in 32 bits
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [SumW:0]   rem_q, rem_d;
  logic [SumW-1:0] den_q, den_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [SumW:0]   shifted;

  always_comb begin
    num_d   = num_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[SumW-1:0], num_q[NumW-1]};
    if (req_i.start) begin
      num_d  = {1'b0, req_i.num, 15'd0} + {{(NumW-SumW+1){1'b0}}, req_i.den[SumW-1:1]};
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = (|quo_q[NumW-1:EntryW]) ? '1 : quo_q[EntryW-1:0];

endmodule

// ===== hdl/sinkhorn_outlier_normalizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sinkhorn_outlier_normalizer_core
// Affinity matrix store with in-place row/column normalization with slack.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   action, row_index, col_index, entry_value
// out_ch    out  result_kind, read_value
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// After reset a clearing pass writes zero to every store entry, one per cycle;
// no item is taken meanwhile. Write: an in-range entry is written as the item is taken.
// Read: the value is returned through the registered store port.
// Normalize: per round, for rows then columns, each line gets a sum pass over the
// line's slack and active entries, a scaling pass dividing each entry by the sum in
// the serial divider, and a slack division; a line whose sum is zero is left as it is.
// Results wait in an output register; no item is taken while one waits.
// ----------------------------------------------------------------------------
module sinkhorn_outlier_normalizer_core #(
  parameter int unsigned MAX_ROWS = 128,
  parameter int unsigned MAX_COLS = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  son_in_if.sink                            in_ch,
  son_out_if.source                         out_ch,
  input  logic                              cfg_we_i,
  input  logic [son_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [son_pkg::CfgW-1:0]          cfg_data_i
);
  import son_pkg::*;

  localparam int unsigned RW      = $clog2(MAX_ROWS);
  localparam int unsigned CW      = $clog2(MAX_COLS);
  localparam int unsigned AW      = RW + CW;
  localparam int unsigned Depth   = MAX_ROWS * MAX_COLS;
  localparam int unsigned NW      = (RW > CW ? RW : CW) + 1;
  localparam int unsigned SlDepth = 2 ** NW;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_RDONE, ST_INIT,
    ST_SUM, ST_SUMADD, ST_DIVRD, ST_DIV, ST_DIVWAIT, ST_SLACK, ST_SLACKWAIT,
    ST_NEXTLINE, ST_FINISH
  } state_e;

  // config
  logic [DimW-1:0]   rows_q, cols_q;
  logic [RoundW-1:0] rounds_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q   <= 8'd128;
      cols_q   <= 8'd128;
      rounds_q <= 5'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS:   rows_q   <= cfg_data_i;
        CFG_COLS:   cols_q   <= cfg_data_i;
        CFG_ROUNDS: rounds_q <= cfg_data_i[RoundW-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] nr, nc;
  logic [RoundW-1:0] nrounds;
  always_comb begin
    nr = (32'(rows_q) > MAX_ROWS) ? NW'(MAX_ROWS) : NW'(rows_q);
    nc = (32'(cols_q) > MAX_COLS) ? NW'(MAX_COLS) : NW'(cols_q);
    nrounds = (rounds_q > RoundMax) ? RoundMax : rounds_q;
  end

  // affinity store
  logic [EntryW-1:0] mem [Depth];
  logic              mwe;
  logic [AW-1:0]     maddr;
  logic [EntryW-1:0] mwdata, mrdata_q;
  always_ff @(posedge clk_i) begin
    if (mwe) mem[maddr] <= mwdata;
    mrdata_q <= mem[maddr];
  end

  state_e state_q, state_d;
  logic [AW:0]       clr_q;
  logic              phase_q;        // 0 rows, 1 columns
  logic [NW-1:0]     line_q, pos_q;  // line = row or column, pos along it
  logic [RoundW-1:0] round_q;
  logic [SumW-1:0]   sum_q;
  logic              rin_q;
  logic              ovalid_q;
  logic              okind_q;
  logic [EntryW-1:0] oval_q;

  // slack store: rows in the lower half, columns in the upper half;
  // the first round of a normalize uses the initial slack
  logic [EntryW-1:0] sl_mem [SlDepth];
  logic              sl_we;
  logic [NW-1:0]     sl_addr;
  logic [EntryW-1:0] sl_rdata_q;

  div_req_t dreq;
  div_rsp_t drsp;
  son_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign sl_addr = {phase_q, line_q[NW-2:0]};
  assign sl_we   = (state_q == ST_SLACKWAIT) && drsp.done;
  always_ff @(posedge clk_i) begin
    if (sl_we) sl_mem[sl_addr] <= drsp.quo;
    sl_rdata_q <= sl_mem[sl_addr];
  end

  logic [NW-1:0] line_len, pos_len;
  logic [RW-1:0] cur_r;
  logic [CW-1:0] cur_c;
  logic [EntryW-1:0] cur_slack;
  logic [SumW-1:0] sum_base, sum_next;
  always_comb begin
    line_len = phase_q ? nc : nr;
    pos_len  = phase_q ? nr : nc;
    cur_r    = phase_q ? pos_q[RW-1:0] : line_q[RW-1:0];
    cur_c    = phase_q ? line_q[CW-1:0] : pos_q[CW-1:0];
    cur_slack = (round_q == '0) ? SlackInit : sl_rdata_q;
    sum_base = (pos_q == '0) ? {{(SumW-EntryW){1'b0}}, cur_slack} : sum_q;
    sum_next = sat_add(sum_base, mrdata_q);
  end

  logic in_ok;
  assign in_ok = (32'(in_ch.row_index) < MAX_ROWS) && (32'(in_ch.col_index) < MAX_COLS);
  assign in_ch.ready = (state_q == ST_IDLE) && !ovalid_q;

  logic acc_in;
  assign acc_in = in_ch.valid && in_ch.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == (AW+1)'(Depth - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (acc_in) begin
          case (action_e'(in_ch.action))
            ACT_READ: state_d = ST_READ;
            ACT_NORM: state_d = ST_INIT;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:   state_d = ST_RDONE;
      ST_RDONE:  state_d = ST_IDLE;
      ST_INIT: begin
        if (nrounds == '0 || nr == '0 || nc == '0) state_d = ST_FINISH;
        else state_d = ST_SUM;
      end
      ST_SUM:    state_d = ST_SUMADD;
      ST_SUMADD: begin
        if (pos_q == pos_len - 1'b1)
          state_d = (sum_next == '0) ? ST_NEXTLINE : ST_DIVRD;
        else state_d = ST_SUM;
      end
      ST_DIVRD:  state_d = ST_DIV;
      ST_DIV:    state_d = ST_DIVWAIT;
      ST_DIVWAIT: begin
        if (drsp.done) state_d = (pos_q == pos_len - 1'b1) ? ST_SLACK : ST_DIVRD;
      end
      ST_SLACK:     state_d = ST_SLACKWAIT;
      ST_SLACKWAIT: if (drsp.done) state_d = ST_NEXTLINE;
      ST_NEXTLINE: begin
        if (line_q != line_len - 1'b1) state_d = ST_SUM;
        else if (!phase_q) state_d = ST_SUM;
        else if (round_q == nrounds - 1'b1) state_d = ST_FINISH;
        else state_d = ST_SUM;
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // store port and divider request
  always_comb begin
    mwe    = 1'b0;
    maddr  = {cur_r, cur_c};
    mwdata = drsp.quo;
    dreq   = '0;
    case (state_q)
      ST_CLEAR: begin
        mwe    = 1'b1;
        maddr  = clr_q[AW-1:0];
        mwdata = '0;
      end
      ST_IDLE: begin
        maddr  = {RW'(in_ch.row_index), CW'(in_ch.col_index)};
        mwdata = (in_ch.entry_value > OneQ15) ? OneQ15 : in_ch.entry_value;
        mwe    = acc_in && (action_e'(in_ch.action) == ACT_WRITE) && in_ok;
        if (acc_in && action_e'(in_ch.action) == ACT_READ && !in_ok) maddr = '0;
      end
      ST_DIV: begin
        dreq.start = 1'b1;
        dreq.num   = mrdata_q;
        dreq.den   = sum_q;
      end
      ST_DIVWAIT: mwe = drsp.done;
      ST_SLACK: begin
        dreq.start = 1'b1;
        dreq.num   = cur_slack;
        dreq.den   = sum_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      ovalid_q <= 1'b0;
      phase_q  <= 1'b0;
      line_q   <= '0;
      pos_q    <= '0;
      round_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: clr_q <= clr_q + 1'b1;
        ST_RDONE: ovalid_q <= 1'b1;
        ST_FINISH: ovalid_q <= 1'b1;
        ST_INIT: begin
          phase_q <= 1'b0;
          line_q  <= '0;
          pos_q   <= '0;
          round_q <= '0;
        end
        ST_SUMADD: if (pos_q == pos_len - 1'b1) pos_q <= '0; else pos_q <= pos_q + 1'b1;
        ST_DIVWAIT: begin
          if (drsp.done) begin
            if (pos_q == pos_len - 1'b1) pos_q <= '0; else pos_q <= pos_q + 1'b1;
          end
        end
        ST_NEXTLINE: begin
          pos_q <= '0;
          if (line_q != line_len - 1'b1) line_q <= line_q + 1'b1;
          else begin
            line_q  <= '0;
            phase_q <= !phase_q;
            if (phase_q) round_q <= round_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      rin_q <= in_ok;
    end
    case (state_q)
      ST_SUMADD: sum_q <= sum_next;
      ST_READ: begin
        okind_q <= KIND_READ;
        oval_q  <= rin_q ? mrdata_q : '0;
      end
      ST_FINISH: begin
        okind_q <= KIND_DONE;
        oval_q  <= '0;
      end
      default: ;
    endcase
  end

  assign out_ch.valid       = ovalid_q;
  assign out_ch.result_kind = okind_q;
  assign out_ch.read_value  = oval_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_no_clear_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_ch.ready) else $error("accept during clear");
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> !drsp.busy) else $error("divider restarted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");

endmodule

// ===== test/tb_sinkhorn_outlier_normalizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sinkhorn_outlier_normalizer_core
// Loads affinity entries, runs slack normalization under several matrix
// sizes and round counts, and reads entries back. Every read and finish
// result is checked against an in-bench model of the store and the slacks.
// ----------------------------------------------------------------------------
module tb_sinkhorn_outlier_normalizer_core;
  import son_pkg::*;

  localparam int unsigned NR = 128;
  localparam int unsigned NC = 128;
  localparam int unsigned STALL_LIMIT = 400000;

  typedef struct packed {
    logic       result_kind;
    logic [15:0] read_value;
  } result_t;

  typedef struct {
    bit          is_cfg;
    cfg_idx_e    idx;
    logic [7:0]  data;
    action_e     act;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [15:0] val;
    bit          typed;
    logic [15:0] want;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  son_in_if  in_if ();
  son_out_if out_if ();

  sinkhorn_outlier_normalizer_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // affinity model
  logic [15:0] aff_m [NR][NC];
  logic [15:0] rslack_m [NR];
  logic [15:0] cslack_m [NC];
  logic [7:0]  rows_m, cols_m;
  logic [4:0]  rounds_m;

  result_t     pending_q [$];
  logic [15:0] typed_q [$];
  bit          typed_flag_q [$];
  bit          next_typed;
  logic [15:0] next_want;
  int          errors = 0;
  int          quiet = 0;
  bit          steady = 0;
  bit          hold_go = 0;

  function automatic logic [15:0] scale_q15(logic [15:0] x, logic [23:0] s);
    logic [63:0] q;
    q = ((64'(x) << 15) + 64'(s >> 1)) / 64'(s);
    return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [23:0] add_sat(logic [23:0] a, logic [15:0] b);
    logic [24:0] s;
    s = {1'b0, a} + 25'(b);
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  task automatic run_normalize();
    int nr, nc, nit;
    logic [23:0] s;
    logic [23:0] csum [NC];
    nr = (rows_m > NR) ? NR : rows_m;
    nc = (cols_m > NC) ? NC : cols_m;
    nit = (rounds_m > 16) ? 16 : rounds_m;
    for (int i = 0; i < NR; i++) rslack_m[i] = SlackInit;
    for (int i = 0; i < NC; i++) cslack_m[i] = SlackInit;
    for (int it = 0; it < nit; it++) begin
      for (int r = 0; r < nr; r++) begin
        s = 24'(rslack_m[r]);
        for (int c = 0; c < nc; c++) s = add_sat(s, aff_m[r][c]);
        if (s != 0) begin
          for (int c = 0; c < nc; c++) aff_m[r][c] = scale_q15(aff_m[r][c], s);
          rslack_m[r] = scale_q15(rslack_m[r], s);
        end
      end
      for (int c = 0; c < nc; c++) csum[c] = 24'(cslack_m[c]);
      for (int r = 0; r < nr; r++)
        for (int c = 0; c < nc; c++) csum[c] = add_sat(csum[c], aff_m[r][c]);
      for (int c = 0; c < nc; c++) begin
        if (csum[c] != 0) begin
          cslack_m[c] = scale_q15(cslack_m[c], csum[c]);
          for (int r = 0; r < nr; r++) aff_m[r][c] = scale_q15(aff_m[r][c], csum[c]);
        end
      end
    end
  endtask

  // transfer monitor: predicts on input, checks on output
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROWS:   rows_m <= cfg_data_i;
          CFG_COLS:   cols_m <= cfg_data_i;
          CFG_ROUNDS: rounds_m <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        case (action_e'(in_if.action))
          ACT_WRITE:
            aff_m[in_if.row_index][in_if.col_index] =
                (in_if.entry_value > OneQ15) ? OneQ15 : in_if.entry_value;
          ACT_NORM: begin
            run_normalize();
            pending_q.push_back({KIND_DONE, 16'd0});
            typed_flag_q.push_back(1'b0);
            typed_q.push_back(16'd0);
          end
          ACT_READ: begin
            pending_q.push_back({KIND_READ, aff_m[in_if.row_index][in_if.col_index]});
            typed_flag_q.push_back(next_typed);
            typed_q.push_back(next_want);
          end
          default: ;
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_q.size() == 0) begin
          $error("result with no expectation: kind %0d value %0d",
                 out_if.result_kind, out_if.read_value);
          errors++;
        end else begin
          result_t e;
          bit tf;
          logic [15:0] tw;
          e = pending_q.pop_front();
          tf = typed_flag_q.pop_front();
          tw = typed_q.pop_front();
          if (tf && tw != e.read_value) begin
            $error("read_value table/model disagree: table %0d model %0d", tw, e.read_value);
            errors++;
          end
          if (out_if.result_kind !== e.result_kind) begin
            $error("result_kind expected %0d actual %0d", e.result_kind, out_if.result_kind);
            errors++;
          end
          if (out_if.read_value !== e.read_value) begin
            $error("read_value expected %0d actual %0d", e.read_value, out_if.read_value);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("[sinkhorn_outlier_normalizer_core] ERROR");
      $finish;
    end
  end

  // result receiver
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        held = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);
      end
    end
  end

  task automatic send(action_e a, logic [6:0] r, logic [6:0] c, logic [15:0] v);
    in_if.valid <= 1'b1;
    in_if.action <= a;
    in_if.row_index <= r;
    in_if.col_index <= c;
    in_if.entry_value <= v;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (!steady && $urandom_range(0, 99) < 30) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e i, logic [7:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= i;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_dims(logic [7:0] r, logic [7:0] c, logic [7:0] n);
    settle();
    write_cfg(CFG_ROWS, r);
    write_cfg(CFG_COLS, c);
    write_cfg(CFG_ROUNDS, n);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_value();
    int k;
    k = $urandom_range(0, 99);
    if (k < 4) return 16'hFFFF;
    if (k < 8) return OneQ15;
    if (k < 14) return 16'd0;
    if (k < 24) return 16'($urandom());
    return 16'($urandom_range(0, 32768));
  endfunction

  task automatic random_items(int n);
    int k, lr, lc;
    lr = (rows_m == 0) ? 1 : ((rows_m > NR) ? NR : rows_m);
    lc = (cols_m == 0) ? 1 : ((cols_m > NC) ? NC : cols_m);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50) begin
        if ($urandom_range(0, 9) < 8)
          send(ACT_WRITE, 7'($urandom_range(0, lr - 1)), 7'($urandom_range(0, lc - 1)),
               pick_value());
        else
          send(ACT_WRITE, 7'($urandom()), 7'($urandom()), pick_value());
      end else if (k < 53) begin
        send(ACT_NORM, 7'($urandom()), 7'($urandom()), 16'($urandom()));
      end else if (k < 95) begin
        if ($urandom_range(0, 1))
          send(ACT_READ, 7'($urandom_range(0, lr - 1)), 7'($urandom_range(0, lc - 1)),
               16'($urandom()));
        else
          send(ACT_READ, 7'($urandom()), 7'($urandom()), 16'($urandom()));
      end else begin
        send(ACT_NONE, 7'($urandom()), 7'($urandom()), 16'($urandom()));
      end
    end
  endtask

  step_t dir_tbl [] = '{
    '{0, CFG_ROWS, 0, ACT_READ,  0,   0,   0,      1, 0},
    '{0, CFG_ROWS, 0, ACT_READ,  127, 127, 0,      1, 0},
    '{0, CFG_ROWS, 0, ACT_WRITE, 0,   0,   16'hFFFF, 0, 0},
    '{0, CFG_ROWS, 0, ACT_READ,  0,   0,   0,      1, 16'd32768},
    '{0, CFG_ROWS, 0, ACT_WRITE, 127, 127, 16'd32768, 0, 0},
    '{0, CFG_ROWS, 0, ACT_READ,  127, 127, 0,      1, 16'd32768},
    '{0, CFG_ROWS, 0, ACT_WRITE, 1,   2,   16'h5555, 0, 0},
    '{0, CFG_ROWS, 0, ACT_READ,  1,   2,   0,      1, 16'h5555},
    '{0, CFG_ROWS, 0, ACT_WRITE, 1,   2,   16'd32769, 0, 0},
    '{0, CFG_ROWS, 0, ACT_READ,  1,   2,   0,      1, 16'd32768},
    '{0, CFG_ROWS, 0, ACT_NONE,  5,   5,   16'd1,  0, 0},
    '{0, CFG_ROWS, 0, ACT_WRITE, 0,   0,   16'd0,  0, 0},
    '{0, CFG_ROWS, 0, ACT_READ,  0,   0,   0,      1, 16'd0},
    '{1, CFG_ROWS,   8'd2, ACT_NONE, 0, 0, 0, 0, 0},
    '{1, CFG_COLS,   8'd3, ACT_NONE, 0, 0, 0, 0, 0},
    '{1, CFG_ROUNDS, 8'd1, ACT_NONE, 0, 0, 0, 0, 0},
    '{0, CFG_ROWS, 0, ACT_WRITE, 0,   1,   16'd16384, 0, 0},
    '{0, CFG_ROWS, 0, ACT_WRITE, 1,   0,   16'd8192,  0, 0},
    '{0, CFG_ROWS, 0, ACT_NORM,  0,   0,   0,      0, 0},
    '{0, CFG_ROWS, 0, ACT_READ,  0,   1,   0,      0, 0},
    '{0, CFG_ROWS, 0, ACT_READ,  1,   2,   0,      0, 0},
    '{0, CFG_ROWS, 0, ACT_READ,  127, 127, 0,      0, 0}
  };

  logic [7:0] ext_r [8] = '{8'd128, 8'd1,   8'd0, 8'd4, 8'd255, 8'd3,  8'd2,  8'd5};
  logic [7:0] ext_c [8] = '{8'd1,   8'd128, 8'd4, 8'd0, 8'd1,   8'd3,  8'd2,  8'd255};
  logic [7:0] ext_n [8] = '{8'd1,   8'd2,   8'd3, 8'd2, 8'd1,   8'd16, 8'd31, 8'd0};

  initial begin
    for (int r = 0; r < NR; r++) begin
      rslack_m[r] = SlackInit;
      for (int c = 0; c < NC; c++) aff_m[r][c] = '0;
    end
    for (int c = 0; c < NC; c++) cslack_m[c] = SlackInit;
    rows_m = 8'd128;
    cols_m = 8'd128;
    rounds_m = 5'd5;
    next_typed = 0;
    next_want = '0;
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.action <= ACT_NONE;
    in_if.row_index <= '0;
    in_if.col_index <= '0;
    in_if.entry_value <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) begin
        settle();
        write_cfg(dir_tbl[i].idx, dir_tbl[i].data);
        @(posedge clk_i);
      end else begin
        next_typed = dir_tbl[i].typed;
        next_want = dir_tbl[i].want;
        send(dir_tbl[i].act, dir_tbl[i].row, dir_tbl[i].col, dir_tbl[i].val);
      end
    end
    next_typed = 0;

    for (int p = 0; p < 16; p++) begin
      if (p < 8) set_dims(ext_r[p], ext_c[p], ext_n[p]);
      else set_dims(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                    8'($urandom_range(1, 4)));
      steady = (p == 5);
      if (p == 3) hold_go = 1;
      random_items(70);
    end
    steady = 0;

    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("[sinkhorn_outlier_normalizer_core] OK");
    end else begin
      $display("[sinkhorn_outlier_normalizer_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/son_pkg.sv
hdl/son_if.sv
hdl/son_div.sv
hdl/sinkhorn_outlier_normalizer_core.sv
test/tb_sinkhorn_outlier_normalizer_core.sv
